// ===== hdl/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg
// shared types, command codes and state encodings for the particle pool
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int POOL_SIZE_DEF = 1024;

    localparam logic [1:0] CMD_SPAWN  = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        OP_SPAWN,
        OP_TICK,
        OP_READ,
        OP_NONE
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPAWN,
        ST_READ,
        ST_TICK
    } back_state_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [9:0]         slot_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [30:0]        drag_rate;
        logic [30:0]        lifetime;
        logic [16:0]        time_step;
    } cmd_item_t;

    typedef struct packed {
        logic [9:0]         slot_out;
        logic               is_active;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [31:0] out_vel_x;
        logic signed [31:0] out_vel_y;
        logic signed [31:0] out_vel_z;
        logic signed [31:0] life_left;
        logic [10:0]        active_count;
    } res_item_t;

    // queue entry: classified operation plus the item
    typedef struct packed {
        op_t       op;
        cmd_item_t item;
    } entry_t;

    // one pool slot as stored in the slot memory
    typedef struct packed {
        logic            active;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [30:0]     drag;
        logic [31:0]     life;
    } row_t;

    // front to back
    typedef struct packed {
        logic head_valid;
        logic full;
    } front_stat_t;

    // back to front
    typedef struct packed {
        logic pop;
        logic clearing;
    } back_ctl_t;

endpackage

// ===== hdl/particle_pool_simulation.sv =====
// ----------------------------------------------------------------------------
// particle_pool_simulation
// fixed particle pool with spawn, euler tick and slot read in q16.16
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  cmd      | in        | cmd_valid, cmd_stall | cmd_item (cmd_item_t)
//  res      | out       | res_valid, res_stall | res_item (res_item_t)
//
//  spawn and read go through ST_SPAWN or ST_READ; unknown codes are answered from ST_IDLE
//  a tick does one slot memory read per slot, four pipeline stages and a
//  write back through the single memory write port
//  after reset a clearing pass writes every slot to zero, with
//  cmd_stall held high
//  a two-entry queue takes items while the back part works or the result
//  register waits on res_stall
// ----------------------------------------------------------------------------
module particle_pool_simulation
    import pps_pkg::*;
#(
    parameter int POOL_SIZE = POOL_SIZE_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd_item,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res_item
);

    front_stat_t fstat;
    back_ctl_t   bctl;
    entry_t      head;

    // front: accept, classify, queue
    pps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .bctl      (bctl),
        .fstat     (fstat),
        .head      (head)
    );

    // back: slot memory, tick pipeline, result register
    pps_back #(.POOL_SIZE(POOL_SIZE)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fstat     (fstat),
        .head      (head),
        .bctl      (bctl),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    // no item taken during the clearing pass
    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        bctl.clearing |-> cmd_stall)
        else $error("item accepted while clearing");

    // full queue must hold off the sender
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        fstat.full |-> cmd_stall)
        else $error("item accepted into full queue");

    // active count never exceeds pool size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (32'(res_item.active_count) <= 32'(POOL_SIZE)))
        else $error("active count out of range");

    // a pop only happens with a queued item
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        bctl.pop |-> fstat.head_valid)
        else $error("pop from empty queue");

endmodule

// ===== hdl/pps_ram.sv =====
// ----------------------------------------------------------------------------
// pps_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/pps_front.sv =====
// ----------------------------------------------------------------------------
// pps_front
// accepts items, classifies the command and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module pps_front
    import pps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  cmd_item_t   cmd_item,
    input  back_ctl_t   bctl,
    output front_stat_t fstat,
    output entry_t      head
);

    entry_t     q_mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       accept;
    logic       pop;
    entry_t     new_entry;

    always_comb
    begin
        new_entry.item = cmd_item;
        unique case (cmd_item.cmd)
            CMD_SPAWN: new_entry.op = OP_SPAWN;
            CMD_TICK:  new_entry.op = OP_TICK;
            CMD_READ:  new_entry.op = OP_READ;
            default:   new_entry.op = OP_NONE;
        endcase
    end

    assign cmd_stall = (count_reg == 2'd2) || bctl.clearing;
    assign accept    = cmd_valid && !cmd_stall;
    assign pop       = bctl.pop && (count_reg != 2'd0);

    always_comb
    begin
        wr_ptr_next = accept ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(accept) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_mem_reg[wr_ptr_reg] <= new_entry;
        end
    end

    assign head             = q_mem_reg[rd_ptr_reg];
    assign fstat.head_valid = (count_reg != 2'd0);
    assign fstat.full       = (count_reg == 2'd2);

endmodule

// ===== hdl/pps_back.sv =====
// ----------------------------------------------------------------------------
// pps_back
// executes spawn, read and tick against the slot memory; owns the result reg
// ----------------------------------------------------------------------------
module pps_back
    import pps_pkg::*;
#(
    parameter int POOL_SIZE = POOL_SIZE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  front_stat_t fstat,
    input  entry_t      head,
    output back_ctl_t   bctl,
    output logic        res_valid,
    input  logic        res_stall,
    output res_item_t   res_item
);

    localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CW = AW + 1;
    localparam int LW = $clog2(POOL_SIZE + 1);
    localparam int RW = $bits(row_t);

    back_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] cursor_reg, cursor_next;
    logic [LW-1:0] live_reg, live_next;
    entry_t        cur_reg, cur_next;
    res_item_t     res_reg, res_next;
    logic          res_valid_reg, res_valid_next;

    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    row_t          wrow, rrow;
    logic [RW-1:0] rdata;

    // tick pipeline
    logic          rv_reg, rv_next;
    logic [AW-1:0] rv_addr_reg, rv_addr_next;
    logic          a_valid_reg, b_valid_reg, c_valid_reg;
    logic [AW-1:0] a_addr_reg, b_addr_reg, c_addr_reg;
    row_t          a_row_reg, b_row_reg, c_row_reg;
    logic signed [31:0] a_life_reg, b_life_reg, c_life_reg;
    logic [47:0]   a_prod_reg;
    logic signed [49:0] b_vprod_reg [3];
    logic signed [31:0] c_vel_reg [3];
    logic signed [49:0] c_pprod_reg [3];

    logic signed [33:0] life_diff;
    logic signed [31:0] life_sat;
    logic [31:0]   drag_q;
    logic signed [17:0] fac_s;
    logic signed [17:0] dt_s;
    logic signed [31:0] vnew [3];
    logic          out_free;
    logic          in_range;
    logic          dead;
    logic          pipe_empty;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
        logic signed [31:0] r;
        if (x > 35'sd2147483647)
        begin
            r = 32'sh7fffffff;
        end
        else if (x < -35'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

    pps_ram #(.WIDTH(RW), .DEPTH(POOL_SIZE), .AW(AW)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wrow),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rrow = row_t'(rdata);
    assign dt_s = $signed({1'b0, cur_reg.item.time_step});

    // stage a: life update and drag product
    always_comb
    begin
        life_diff = 34'($signed(rrow.life)) - 34'($signed({1'b0, cur_reg.item.time_step}));
        life_sat  = sat32(35'(life_diff));
    end

    // stage b: drag factor clamped at zero
    always_comb
    begin
        drag_q = a_prod_reg[47:16];
        if (drag_q[31:16] != 16'd0)
        begin
            fac_s = 18'sd0;
        end
        else
        begin
            fac_s = 18'sd65536 - $signed({2'b00, drag_q[15:0]});
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            vnew[k] = b_vprod_reg[k][47:16];
        end
    end

    always_ff @(posedge clk)
    begin
        rv_addr_reg <= rv_addr_next;
        a_addr_reg  <= rv_addr_reg;
        a_row_reg   <= rrow;
        a_life_reg  <= life_sat;
        a_prod_reg  <= 48'(rrow.drag) * 48'(cur_reg.item.time_step);
        b_addr_reg  <= a_addr_reg;
        b_row_reg   <= a_row_reg;
        b_life_reg  <= a_life_reg;
        c_addr_reg  <= b_addr_reg;
        c_row_reg   <= b_row_reg;
        c_life_reg  <= b_life_reg;
        for (int k = 0; k < 3; k++)
        begin
            b_vprod_reg[k] <= $signed(a_row_reg.vel[k]) * fac_s;
            c_vel_reg[k]   <= vnew[k];
            c_pprod_reg[k] <= vnew[k] * dt_s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg      <= 1'b0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            rv_reg      <= rv_next;
            a_valid_reg <= rv_reg && rrow.active;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    assign out_free   = !res_valid_reg || !res_stall;
    assign in_range   = 32'(cur_reg.item.slot_index) < 32'(POOL_SIZE);
    assign dead       = (c_life_reg <= 32'sd0);
    assign pipe_empty = !rv_reg && !a_valid_reg && !b_valid_reg && !c_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cursor_next    = cursor_reg;
        live_next      = live_reg;
        cur_next       = cur_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        rv_next        = 1'b0;
        rv_addr_next   = rv_addr_reg;
        we             = 1'b0;
        waddr          = '0;
        wrow           = '0;
        re             = 1'b0;
        raddr          = '0;
        bctl.pop       = 1'b0;
        bctl.clearing  = (state_reg == ST_CLEAR);

        unique case (state_reg)
            ST_CLEAR:
            begin
                we    = 1'b1;
                waddr = cnt_reg[AW-1:0];
                if (cnt_reg == CW'(POOL_SIZE - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (fstat.head_valid && out_free)
                begin
                    bctl.pop = 1'b1;
                    cur_next = head;
                    unique case (head.op)
                        OP_SPAWN:
                        begin
                            re         = 1'b1;
                            raddr      = cursor_reg;
                            state_next = ST_SPAWN;
                        end
                        OP_READ:
                        begin
                            re         = 1'b1;
                            raddr      = AW'(head.item.slot_index);
                            state_next = ST_READ;
                        end
                        OP_TICK:
                        begin
                            cnt_next   = '0;
                            state_next = ST_TICK;
                        end
                        default:
                        begin
                            res_next              = '0;
                            res_next.active_count = 11'(live_reg);
                            res_valid_next        = 1'b1;
                        end
                    endcase
                end
            end
            ST_SPAWN:
            begin
                we          = 1'b1;
                waddr       = cursor_reg;
                wrow.active = 1'b1;
                wrow.pos[0] = cur_reg.item.pos_x;
                wrow.pos[1] = cur_reg.item.pos_y;
                wrow.pos[2] = cur_reg.item.pos_z;
                wrow.vel[0] = cur_reg.item.vel_x;
                wrow.vel[1] = cur_reg.item.vel_y;
                wrow.vel[2] = cur_reg.item.vel_z;
                wrow.drag   = cur_reg.item.drag_rate;
                wrow.life   = {1'b0, cur_reg.item.lifetime};
                if (!rrow.active)
                begin
                    live_next = live_reg + 1'b1;
                end
                cursor_next = (cursor_reg == AW'(POOL_SIZE - 1)) ? '0 : cursor_reg + 1'b1;
                res_next              = '0;
                res_next.slot_out     = 10'(cursor_reg);
                res_next.active_count = 11'(live_next);
                res_valid_next        = 1'b1;
                state_next            = ST_IDLE;
            end
            ST_READ:
            begin
                res_next          = '0;
                res_next.slot_out = cur_reg.item.slot_index;
                if (in_range)
                begin
                    res_next.is_active = rrow.active;
                    res_next.out_pos_x = rrow.pos[0];
                    res_next.out_pos_y = rrow.pos[1];
                    res_next.out_pos_z = rrow.pos[2];
                    res_next.out_vel_x = rrow.vel[0];
                    res_next.out_vel_y = rrow.vel[1];
                    res_next.out_vel_z = rrow.vel[2];
                    res_next.life_left = rrow.life;
                end
                res_next.active_count = 11'(live_reg);
                res_valid_next        = 1'b1;
                state_next            = ST_IDLE;
            end
            ST_TICK:
            begin
                // issue one slot read per cycle
                if (cnt_reg < CW'(POOL_SIZE))
                begin
                    re           = 1'b1;
                    raddr        = cnt_reg[AW-1:0];
                    rv_next      = 1'b1;
                    rv_addr_next = cnt_reg[AW-1:0];
                    cnt_next     = cnt_reg + 1'b1;
                end
                // write back of the last stage
                if (c_valid_reg)
                begin
                    we          = 1'b1;
                    waddr       = c_addr_reg;
                    wrow        = c_row_reg;
                    wrow.life   = c_life_reg;
                    if (dead)
                    begin
                        wrow.active = 1'b0;
                        if (live_reg != '0)
                        begin
                            live_next = live_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            wrow.vel[k] = c_vel_reg[k];
                            wrow.pos[k] = sat32(35'($signed(c_row_reg.pos[k]))
                                                + 35'($signed(c_pprod_reg[k][49:16])));
                        end
                    end
                end
                if (cnt_reg == CW'(POOL_SIZE) && pipe_empty)
                begin
                    res_next              = '0;
                    res_next.active_count = 11'(live_reg);
                    res_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            cursor_reg    <= '0;
            live_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cursor_reg    <= cursor_next;
            live_reg      <= live_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

endmodule

// ===== tb/particle_pool_simulation_tb.sv =====
// ----------------------------------------------------------------------------
// particle_pool_simulation_tb
// spawn, tick, read and unused-code items run through the particle pool against a local
// fixed-point predictor; each result item is compared whole, in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module particle_pool_simulation_tb;
    import pps_pkg::*;

    localparam int NSLOT = 1024;
    localparam int SAT_MAX = 32'sh7fffffff;
    localparam int SAT_MIN = 32'sh80000000;
    localparam longint CYCLE_LIMIT = 64'd3000000;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    cmd_item_t cmd_item;
    logic      res_valid;
    logic      res_stall;
    res_item_t res_item;

    particle_pool_simulation DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    // predictor copy of the pool
    logic [9:0]  pool_cursor;
    logic [10:0] pool_live;
    logic        pool_flag [NSLOT];
    logic signed [31:0] pool_pos [NSLOT][3];
    logic signed [31:0] pool_vel [NSLOT][3];
    logic signed [31:0] pool_drag [NSLOT];
    logic signed [31:0] pool_life [NSLOT];

    cmd_item_t pending_items [$];
    res_item_t expected_results [$];

    int  mismatches;
    int  sender_idle_pct;
    int  receiver_idle_pct;
    bit  cmd_taken;
    longint cycles;

    always #2 clk = ~clk;

    // arithmetic shift right by 16 gives floor rounding
    function automatic longint floor16(input longint x);
        return x >>> 16;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint x);
        if (x > SAT_MAX)
            return SAT_MAX;
        if (x < SAT_MIN)
            return SAT_MIN;
        return x[31:0];
    endfunction

    function automatic void advance_pool(input longint dt);
        longint life;
        longint factor;
        longint v;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (!pool_flag[i])
                continue;
            life = clamp32(longint'(pool_life[i]) - dt);
            pool_life[i] = life[31:0];
            if (life <= 0)
            begin
                // dying slot keeps its position and velocity
                pool_flag[i] = 1'b0;
                if (pool_live > 0)
                    pool_live--;
                continue;
            end
            factor = 65536 - floor16(longint'(pool_drag[i]) * dt);
            if (factor < 0)
                factor = 0;
            for (int k = 0; k < 3; k++)
            begin
                v = floor16(longint'(pool_vel[i][k]) * factor);
                pool_vel[i][k] = v[31:0];
                pool_pos[i][k] = clamp32(longint'(pool_pos[i][k]) + floor16(v * dt));
            end
        end
    endfunction

    function automatic res_item_t pool_apply(input cmd_item_t it);
        res_item_t r;
        int s;
        r = '0;
        case (it.cmd)
            CMD_SPAWN:
            begin
                s = int'(pool_cursor);
                pool_pos[s][0] = it.pos_x;
                pool_pos[s][1] = it.pos_y;
                pool_pos[s][2] = it.pos_z;
                pool_vel[s][0] = it.vel_x;
                pool_vel[s][1] = it.vel_y;
                pool_vel[s][2] = it.vel_z;
                pool_drag[s] = {1'b0, it.drag_rate};
                pool_life[s] = {1'b0, it.lifetime};
                if (!pool_flag[s])
                begin
                    pool_flag[s] = 1'b1;
                    pool_live++;
                end
                pool_cursor = pool_cursor + 10'd1;
                r.slot_out = s[9:0];
            end
            CMD_TICK:
                advance_pool(longint'(it.time_step));
            CMD_READ:
            begin
                s = int'(it.slot_index);
                r.slot_out = it.slot_index;
                r.is_active = pool_flag[s];
                r.out_pos_x = pool_pos[s][0];
                r.out_pos_y = pool_pos[s][1];
                r.out_pos_z = pool_pos[s][2];
                r.out_vel_x = pool_vel[s][0];
                r.out_vel_y = pool_vel[s][1];
                r.out_vel_z = pool_vel[s][2];
                r.life_left = pool_life[s];
            end
            default:
                ;
        endcase
        r.active_count = pool_live;
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 1) ? 32'hffffffff : 32'h0;
            3: return $urandom_range(0, 32'h40000) - 32'h20000;
            default: return $urandom;
        endcase
    endfunction

    function automatic cmd_item_t spawn_item(input int life_cap, input int drag_max);
        cmd_item_t it;
        it = '0;
        it.cmd = CMD_SPAWN;
        it.slot_index = 10'($urandom);
        it.pos_x = rand_word();
        it.pos_y = rand_word();
        it.pos_z = rand_word();
        it.vel_x = rand_word();
        it.vel_y = rand_word();
        it.vel_z = rand_word();
        it.drag_rate = 31'($urandom_range(0, drag_max));
        it.lifetime = 31'($urandom_range(0, life_cap));
        it.time_step = 17'($urandom);
        return it;
    endfunction

    function automatic cmd_item_t tick_item(input logic [16:0] dt);
        cmd_item_t it;
        it = spawn_item(32'h7fffffff, 32'h7fffffff);
        it.cmd = CMD_TICK;
        it.time_step = dt;
        return it;
    endfunction

    function automatic cmd_item_t read_item(input logic [9:0] idx);
        cmd_item_t it;
        it = spawn_item(32'h7fffffff, 32'h7fffffff);
        it.cmd = CMD_READ;
        it.slot_index = idx;
        return it;
    endfunction

    // driver: next item on the falling edge, held until taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!cmd_valid || cmd_taken)
            begin
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    cmd_item <= pending_items.pop_front();
                    cmd_valid <= 1'b1;
                end
                else
                    cmd_valid <= 1'b0;
            end
            res_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
        end
    end

    // predict on accepted commands, check accepted results
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        cmd_taken <= rst_n && cmd_valid && !cmd_stall;
        if (rst_n && cmd_valid && !cmd_stall)
            expected_results.push_back(pool_apply(cmd_item));
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %p", res_item);
            end
            else
            begin
                res_item_t exp_r;
                exp_r = expected_results.pop_front();
                if (res_item !== exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch\n  expected %p\n  actual   %p", exp_r, res_item);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // stimulus: directed corners, then random phases with changing idle rates
    initial
    begin
        cmd_item_t it;
        clk = 1'b0;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd_item = '0;
        res_stall = 1'b0;
        mismatches = 0;
        cycles = 0;
        sender_idle_pct = 20;
        receiver_idle_pct = 67;
        pool_cursor = '0;
        pool_live = '0;
        for (int i = 0; i < NSLOT; i++)
        begin
            pool_flag[i] = 1'b0;
            pool_drag[i] = '0;
            pool_life[i] = '0;
            for (int k = 0; k < 3; k++)
            begin
                pool_pos[i][k] = '0;
                pool_vel[i][k] = '0;
            end
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // read of untouched slots
        pending_items.push_back(read_item(10'd0));
        pending_items.push_back(read_item(10'd1023));
        // extreme spawns: zero life, max life, max drag, extreme vectors
        it = spawn_item(0, 0);
        it.lifetime = '0;
        pending_items.push_back(it);
        it = spawn_item(0, 0);
        it.lifetime = 31'h7fffffff;
        it.drag_rate = 31'h7fffffff;
        it.pos_x = 32'h7fffffff; it.pos_y = 32'h80000000; it.pos_z = 32'hffffffff;
        it.vel_x = 32'h80000000; it.vel_y = 32'h7fffffff; it.vel_z = 32'h0;
        pending_items.push_back(it);
        it = spawn_item(0, 0);
        it.lifetime = 31'h7fffffff;
        it.drag_rate = '0;
        it.pos_x = 32'h7fff0000; it.pos_y = 32'h80010000;
        it.vel_x = 32'h7fffffff; it.vel_y = 32'h80000000; it.vel_z = 32'hffffffff;
        pending_items.push_back(it);
        it = spawn_item(32'h30000, 32'h8000);
        it.lifetime = 31'h10000;
        pending_items.push_back(it);
        pending_items.push_back(tick_item(17'd0));
        pending_items.push_back(read_item(10'd2));
        // full-second step, then the largest step, just under two seconds
        pending_items.push_back(tick_item(17'h10000));
        pending_items.push_back(tick_item(17'h1ffff));
        for (int i = 0; i < 5; i++)
            pending_items.push_back(read_item(i[9:0]));
        it = tick_item(17'd1);
        it.cmd = CMD_UNUSED;
        pending_items.push_back(it);
        pending_items.push_back(read_item(10'd0));

        // three idle phases, ticks kept rare since each walks the pool
        for (int ph = 0; ph < 3; ph++)
        begin
            wait (pending_items.size() == 0 && expected_results.size() == 0);
            if (ph == 1)
            begin
                sender_idle_pct = 67;
                receiver_idle_pct = 20;
            end
            else if (ph == 2)
            begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            for (int n = 0; n < 190; n++)
            begin
                int sel;
                sel = $urandom_range(0, 99);
                if (sel < 45)
                    pending_items.push_back(spawn_item(
                        $urandom_range(0, 1) ? 32'h7fffffff : 32'h60000,
                        $urandom_range(0, 1) ? 32'h7fffffff : 32'h20000));
                else if (sel < 53)
                    pending_items.push_back(tick_item($urandom_range(0, 3) == 0 ?
                        17'($urandom) : 17'($urandom_range(0, 32'h10000))));
                else if (sel < 97)
                    pending_items.push_back(read_item($urandom_range(0, 2) == 0 ?
                        10'($urandom) : pool_cursor - 10'($urandom_range(1, 8))));
                else
                begin
                    it = tick_item(17'($urandom));
                    it.cmd = CMD_UNUSED;
                    pending_items.push_back(it);
                end
            end
        end

        wait (pending_items.size() == 0 && expected_results.size() == 0);
        repeat (2000) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
